FILE: src/aisq_pkg.sv
// shared types and constants for the stick autorepeat block
package aisq_pkg;

  localparam logic [1:0] MODE_PRESS   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_STICK   = 2'd2;
  localparam logic [1:0] MODE_POLL    = 2'd3;

  localparam logic [3:0] ACT_NONE  = 4'd0;
  localparam logic [3:0] ACT_UP    = 4'd1;
  localparam logic [3:0] ACT_DOWN  = 4'd2;
  localparam logic [3:0] ACT_LEFT  = 4'd3;
  localparam logic [3:0] ACT_RIGHT = 4'd4;
  localparam logic [3:0] ACT_LAST  = 4'd11;

  localparam logic [1:0] AXIS_VERT  = 2'd0;
  localparam logic [1:0] AXIS_HORIZ = 2'd1;

  localparam logic [1:0] REG_DELAY     = 2'd0;
  localparam logic [1:0] REG_PERIOD    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam logic [15:0] DELAY_RST     = 16'd320;
  localparam logic [15:0] PERIOD_RST    = 16'd90;
  localparam logic [14:0] THRESHOLD_RST = 15'd16000;

  // stick codes, 3-bit two's complement
  localparam logic [2:0] CODE_CENTER = 3'b000;
  localparam logic [2:0] CODE_RIGHT  = 3'b001;
  localparam logic [2:0] CODE_DOWN   = 3'b010;
  localparam logic [2:0] CODE_UP     = 3'b110;
  localparam logic [2:0] CODE_LEFT   = 3'b111;

  typedef struct packed {
    logic [15:0] hold_delay_ms;
    logic [15:0] repeat_period_ms;
    logic [14:0] axis_threshold;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         action;
    logic               os_repeat;
    logic [1:0]         stick_axis;
    logic signed [15:0] stick_value;
    logic [31:0]        time_ms;
  } ev_t;

  typedef struct packed {
    logic       axis_ok;
    logic       dir_nz;
    logic [2:0] code;
    logic [3:0] act;
  } stick_q_t;

endpackage

FILE: src/aisq_stick.sv
// stick sample quantizer: threshold compare to direction code and action
module aisq_stick import aisq_pkg::*; (
  input  logic [1:0]         stick_axis,
  input  logic signed [15:0] stick_value,
  input  logic [14:0]        threshold,
  output stick_q_t           q
);

  logic signed [16:0] val_ext;
  logic signed [16:0] thr_pos;
  logic signed [16:0] thr_neg;
  logic               vert;
  logic               pos;
  logic               neg;

  always_comb begin
    val_ext = {stick_value[15], stick_value};
    thr_pos = $signed({2'b00, threshold});
    thr_neg = 17'sd0 - thr_pos;
    vert    = (stick_axis == AXIS_VERT);
    pos     = val_ext > thr_pos;
    neg     = val_ext < thr_neg;

    q.axis_ok = (stick_axis == AXIS_VERT) || (stick_axis == AXIS_HORIZ);
    q.dir_nz  = pos || neg;
    if (pos) begin
      q.code = vert ? CODE_DOWN : CODE_RIGHT;
      q.act  = vert ? ACT_DOWN : ACT_RIGHT;
    end else if (neg) begin
      q.code = vert ? CODE_UP : CODE_LEFT;
      q.act  = vert ? ACT_UP : ACT_LEFT;
    end else begin
      q.code = CODE_CENTER;
      q.act  = ACT_NONE;
    end
  end

endmodule

FILE: src/aisq_core.sv
// hold state, timers and per-event result selection
module aisq_core import aisq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  ev_t        ev,
  input  cfg_t       cfg,
  output logic [3:0] res
);

  logic [3:0]  held_action_r, held_action_nxt;
  logic [31:0] held_start_r, held_start_nxt;
  logic [31:0] last_emit_r, last_emit_nxt;
  logic [2:0]  stick_code_r, stick_code_nxt;

  stick_q_t    sq;
  logic [3:0]  act;
  logic        is_dir;
  logic [31:0] since_hold;
  logic [31:0] since_emit;

  aisq_stick u_stick (
    .stick_axis  (ev.stick_axis),
    .stick_value (ev.stick_value),
    .threshold   (cfg.axis_threshold),
    .q           (sq)
  );

  always_comb begin
    act        = (ev.action > ACT_LAST) ? ACT_NONE : ev.action;
    is_dir     = (act >= ACT_UP) && (act <= ACT_RIGHT);
    since_hold = ev.time_ms - held_start_r;
    since_emit = ev.time_ms - last_emit_r;

    held_action_nxt = held_action_r;
    held_start_nxt  = held_start_r;
    last_emit_nxt   = last_emit_r;
    stick_code_nxt  = stick_code_r;
    res             = ACT_NONE;

    unique case (ev.mode)
      MODE_PRESS: begin
        if (!ev.os_repeat) begin
          res = act;
          if (is_dir) begin
            held_action_nxt = act;
            held_start_nxt  = ev.time_ms;
            last_emit_nxt   = ev.time_ms;
          end
        end
      end
      MODE_RELEASE: begin
        if (act == held_action_r) held_action_nxt = ACT_NONE;
      end
      MODE_STICK: begin
        if (sq.axis_ok && (sq.code != stick_code_r)) begin
          stick_code_nxt = sq.code;
          if (!sq.dir_nz) begin
            held_action_nxt = ACT_NONE;
          end else begin
            held_action_nxt = sq.act;
            held_start_nxt  = ev.time_ms;
            last_emit_nxt   = ev.time_ms;
            res             = sq.act;
          end
        end
      end
      MODE_POLL: begin
        if ((held_action_r != ACT_NONE) &&
            (since_hold >= {16'd0, cfg.hold_delay_ms}) &&
            (since_emit >= {16'd0, cfg.repeat_period_ms})) begin
          last_emit_nxt = ev.time_ms;
          res           = held_action_r;
        end
      end
      default: res = ACT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_action_r <= ACT_NONE;
      held_start_r  <= 32'd0;
      last_emit_r   <= 32'd0;
      stick_code_r  <= CODE_CENTER;
    end else if (advance) begin
      held_action_r <= held_action_nxt;
      held_start_r  <= held_start_nxt;
      last_emit_r   <= last_emit_nxt;
      stick_code_r  <= stick_code_nxt;
    end
  end

endmodule

FILE: src/input_autorepeat_stick_quantizer.sv
// top level: event input register, config registers, result register
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid / in_ready | mode, action, os_repeat, stick_axis,
//          |                     | stick_value, time_ms
//  out     | out_valid/out_ready | result_action, one per event
//  cfg     | cfg_we              | cfg_index, cfg_data (no wait, no read-back)
//
// one event per cycle sustained while out_ready is high; an event waits in the
// input register, then its result lands in the output register
// the hold/timer update and result pick are one short compare-and-select pass
// synchronous active-low reset clears both valid flags, hold state and
// config registers to their defaults
// a stalled output holds its result while the input register still takes a
// transfer if it is empty; both stages move together when out_ready is high
module input_autorepeat_stick_quantizer import aisq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [3:0]         in_action,
  input  logic               in_os_repeat,
  input  logic [1:0]         in_stick_axis,
  input  logic signed [15:0] in_stick_value,
  input  logic [31:0]        in_time_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_result_action,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t       cfg_r;
  ev_t        ev_r;
  logic       ev_valid_r;
  logic       out_valid_r;
  logic [3:0] out_result_r;
  logic [3:0] res;
  logic       advance;

  // event leaves the input register when the output slot is free or draining
  assign advance  = ev_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !ev_valid_r || advance;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_delay_ms    <= DELAY_RST;
      cfg_r.repeat_period_ms <= PERIOD_RST;
      cfg_r.axis_threshold   <= THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELAY:     cfg_r.hold_delay_ms    <= cfg_data;
        REG_PERIOD:    cfg_r.repeat_period_ms <= cfg_data;
        REG_THRESHOLD: cfg_r.axis_threshold   <= cfg_data[14:0];
        default:       ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
    end else if (in_ready) begin
      ev_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev_r.mode        <= in_mode;
      ev_r.action      <= in_action;
      ev_r.os_repeat   <= in_os_repeat;
      ev_r.stick_axis  <= in_stick_axis;
      ev_r.stick_value <= in_stick_value;
      ev_r.time_ms     <= in_time_ms;
    end
  end

  // state update and result selection
  aisq_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .ev      (ev_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_result_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_result_action = out_result_r;

endmodule

FILE: tb/tb_top.sv
// testbench for the stick autorepeat block: predictor scoreboard, drivers, checks
module tb_top;
  import aisq_pkg::*;

  // action codes that the package does not name
  localparam logic [3:0] ACT_CONFIRM  = 4'd5;
  localparam logic [3:0] ACT_BACK     = 4'd6;
  localparam logic [3:0] ACT_BAD_LOW  = 4'd12;
  localparam logic [3:0] ACT_BAD_HIGH = 4'd15;

  // cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT = 2000;

  // predicts one result_action per event and matches it against the block
  class autorepeat_scoreboard;
    cfg_t        cfg;
    logic [3:0]  held_action;
    logic [31:0] held_start_ms;
    logic [31:0] last_emit_ms;
    logic [2:0]  stick_code;
    logic [3:0]  expected_q[$];
    int          errors;
    int          hits;

    function new();
      cfg           = '{DELAY_RST, PERIOD_RST, THRESHOLD_RST};
      held_action   = ACT_NONE;
      held_start_ms = '0;
      last_emit_ms  = '0;
      stick_code    = CODE_CENTER;
      errors        = 0;
      hits          = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_DELAY:     cfg.hold_delay_ms    = data;
        REG_PERIOD:    cfg.repeat_period_ms = data;
        REG_THRESHOLD: cfg.axis_threshold   = data[14:0];
        default: ;
      endcase
    endfunction

    function void note_event(ev_t e);
      logic [3:0]  act;
      logic [3:0]  res;
      logic [3:0]  dir_act;
      logic [2:0]  code;
      logic [31:0] since_hold;
      logic [31:0] since_emit;
      int          val;
      int          thr;
      int          dir;
      act = (e.action > ACT_LAST) ? ACT_NONE : e.action;
      res = ACT_NONE;
      case (e.mode)
        MODE_PRESS: begin
          if (!e.os_repeat) begin
            if (act >= ACT_UP && act <= ACT_RIGHT) begin
              held_action   = act;
              held_start_ms = e.time_ms;
              last_emit_ms  = e.time_ms;
            end
            res = act;
          end
        end
        MODE_RELEASE: begin
          if (act == held_action) held_action = ACT_NONE;
        end
        MODE_STICK: begin
          if (e.stick_axis == AXIS_VERT || e.stick_axis == AXIS_HORIZ) begin
            val = $signed(e.stick_value);
            thr = {17'd0, cfg.axis_threshold};
            dir = (val > thr) ? 1 : (val < -thr) ? -1 : 0;
            if (e.stick_axis == AXIS_VERT) begin
              code    = (dir > 0) ? CODE_DOWN : (dir < 0) ? CODE_UP : CODE_CENTER;
              dir_act = (dir > 0) ? ACT_DOWN : ACT_UP;
            end else begin
              code    = (dir > 0) ? CODE_RIGHT : (dir < 0) ? CODE_LEFT : CODE_CENTER;
              dir_act = (dir > 0) ? ACT_RIGHT : ACT_LEFT;
            end
            if (code != stick_code) begin
              stick_code = code;
              if (dir == 0) begin
                held_action = ACT_NONE;
              end else begin
                held_action   = dir_act;
                held_start_ms = e.time_ms;
                last_emit_ms  = e.time_ms;
                res           = dir_act;
              end
            end
          end
        end
        default: begin
          // poll tick, differences wrap at 32 bits
          since_hold = e.time_ms - held_start_ms;
          since_emit = e.time_ms - last_emit_ms;
          if (held_action != ACT_NONE && since_hold >= {16'd0, cfg.hold_delay_ms} &&
              since_emit >= {16'd0, cfg.repeat_period_ms}) begin
            last_emit_ms = e.time_ms;
            res          = held_action;
          end
        end
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [3:0] got);
      logic [3:0] want;
      if (expected_q.size() == 0) begin
        $error("result_action: expected nothing, actual %0d", got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $error("result_action: expected %0d, actual %0d", want, got);
          errors++;
        end else if (want != ACT_NONE) begin
          hits++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [1:0]         in_mode        = MODE_POLL;
  logic [3:0]         in_action      = ACT_NONE;
  logic               in_os_repeat   = 1'b0;
  logic [1:0]         in_stick_axis  = AXIS_VERT;
  logic signed [15:0] in_stick_value = '0;
  logic [31:0]        in_time_ms     = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [3:0]         out_result_action;
  logic               cfg_we         = 1'b0;
  logic [1:0]         cfg_index      = REG_DELAY;
  logic [15:0]        cfg_data       = '0;

  autorepeat_scoreboard sb;

  // stimulus bookkeeping
  int          sent_items = 0;
  int          settings_used = 1;
  int          stall_cycles = 0;
  logic        quiet = 1'b0;   // no idling on either side while set
  logic [31:0] now_ms = '0;    // running event timestamp

  input_autorepeat_stick_quantizer uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_action         (in_action),
    .in_os_repeat      (in_os_repeat),
    .in_stick_axis     (in_stick_axis),
    .in_stick_value    (in_stick_value),
    .in_time_ms        (in_time_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_action (out_result_action),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random back-pressure, out_ready low about 12 percent of the time
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 12);
  end

  // every accepted result is matched against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_result_action);
  end

  // hang detection: counts cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one event transfer; valid stays up until the block takes it
  task automatic send_event(logic [1:0] mode, logic [3:0] act, logic osrep,
                            logic [1:0] axis, logic [15:0] value, logic [31:0] t);
    ev_t e;
    e = '{mode, act, osrep, axis, value, t};
    if (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_action      <= act;
    in_os_repeat   <= osrep;
    in_stick_axis  <= axis;
    in_stick_value <= value;
    in_time_ms     <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_event(e);
    sent_items++;
  endtask

  // poll tick with junk in the fields that polls ignore
  task automatic send_poll(logic [31:0] t);
    send_event(MODE_POLL, 4'($urandom), 1'($urandom), 2'($urandom), 16'($urandom), t);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all three registers back to back, only while the block is idle
  task automatic configure(logic [15:0] delay, logic [15:0] period, logic [14:0] thr);
    logic [1:0]  idx[3];
    logic [15:0] vals[3];
    idx  = '{REG_DELAY, REG_PERIOD, REG_THRESHOLD};
    vals = '{delay, period, {1'b0, thr}};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // mostly short steps, sometimes long enough to beat the largest timers
  function automatic void advance_clock();
    if ($urandom_range(0, 3) == 0) now_ms += $urandom_range(0, 70000);
    else now_ms += $urandom_range(0, 200);
  endfunction

  // stick positions clustered around the threshold edges
  function automatic logic [15:0] stick_sample(int thr);
    int v;
    case ($urandom_range(0, 5))
      0:       v = thr + 1 + $urandom_range(0, 64);
      1:       v = -thr - 1 - $urandom_range(0, 64);
      2:       v = thr;
      3:       v = -thr;
      4:       v = 0;
      default: v = $urandom;
    endcase
    return v[15:0];
  endfunction

  // random traffic: key holds, stick sweeps, poll runs and some pure noise
  task automatic run_random(int n);
    int         stop;
    int         kind;
    logic [3:0] a;
    logic [1:0] ax;
    stop = sent_items + n;
    case ($urandom_range(0, 2))
      0:       now_ms = $urandom_range(0, 1000);
      1:       now_ms = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);  // close to the wrap
      default: now_ms = $urandom;
    endcase
    while (sent_items < stop) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        // key hold: press, polls with system repeats mixed in, release
        a = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(ACT_UP, ACT_RIGHT));
        send_event(MODE_PRESS, a, 1'b0, 2'($urandom), 16'($urandom), now_ms);
        repeat ($urandom_range(1, 8)) begin
          advance_clock();
          if ($urandom_range(0, 4) == 0)
            send_event(MODE_PRESS, a, 1'b1, 2'($urandom), 16'($urandom), now_ms);
          else
            send_poll(now_ms);
        end
        advance_clock();
        if ($urandom_range(0, 4) == 0) a = 4'($urandom);
        send_event(MODE_RELEASE, a, 1'($urandom), 2'($urandom), 16'($urandom), now_ms);
      end else if (kind <= 6) begin
        // stick sweep around the threshold, then back to center
        ax = 2'($urandom_range(0, 1));
        repeat ($urandom_range(2, 8)) begin
          advance_clock();
          if ($urandom_range(0, 2) == 0)
            send_poll(now_ms);
          else
            send_event(MODE_STICK, 4'($urandom), 1'($urandom),
                       ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3)) : ax,
                       stick_sample(int'(sb.cfg.axis_threshold)), now_ms);
          if ($urandom_range(0, 3) == 0) ax = ax ^ 2'b01;
        end
        advance_clock();
        send_event(MODE_STICK, 4'($urandom), 1'($urandom), ax, 16'd0, now_ms);
      end else if (kind <= 8) begin
        repeat ($urandom_range(1, 6)) begin
          advance_clock();
          send_poll(now_ms);
        end
      end else begin
        send_event(2'($urandom), 4'($urandom), 1'($urandom), 2'($urandom),
                   16'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners at the reset settings
    send_event(MODE_PRESS, ACT_NONE, 1'b0, 2'($urandom), 16'($urandom), 32'd100);
    send_event(MODE_PRESS, ACT_CONFIRM, 1'b0, 2'($urandom), 16'($urandom), 32'd110);
    send_event(MODE_PRESS, ACT_LAST, 1'b0, 2'($urandom), 16'($urandom), 32'd120);
    // out-of-range action codes act as none
    send_event(MODE_PRESS, ACT_BAD_HIGH, 1'b0, 2'($urandom), 16'($urandom), 32'd130);
    send_event(MODE_PRESS, ACT_BAD_LOW, 1'b0, 2'($urandom), 16'($urandom), 32'd140);
    // hold up, system repeat ignored, timers before and after expiry
    send_event(MODE_PRESS, ACT_UP, 1'b0, 2'($urandom), 16'($urandom), 32'd1000);
    send_event(MODE_PRESS, ACT_UP, 1'b1, 2'($urandom), 16'($urandom), 32'd1010);
    send_poll(32'd1100);
    send_poll(32'd1320);
    send_poll(32'd1400);
    send_poll(32'd1410);
    // release of something not held, then the held key
    send_event(MODE_RELEASE, ACT_DOWN, 1'b0, 2'($urandom), 16'($urandom), 32'd1500);
    send_event(MODE_RELEASE, ACT_UP, 1'b0, 2'($urandom), 16'($urandom), 32'd1510);
    send_poll(32'd2000);
    // stick extremes, unchanged code, ignored axes
    send_event(MODE_STICK, ACT_BACK, 1'b1, AXIS_VERT, 16'h7FFF, 32'd3000);
    send_event(MODE_STICK, ACT_NONE, 1'b0, AXIS_VERT, 16'h7FFF, 32'd3005);
    send_event(MODE_STICK, ACT_NONE, 1'b0, AXIS_HORIZ, 16'h8000, 32'd3010);
    send_event(MODE_STICK, ACT_NONE, 1'b0, 2'd2, 16'h7FFF, 32'd3020);
    send_event(MODE_STICK, ACT_NONE, 1'b0, 2'd3, 16'h8000, 32'd3030);
    // exactly at the threshold is centered, one past it is a direction
    send_event(MODE_STICK, ACT_NONE, 1'b0, AXIS_HORIZ, 16'(THRESHOLD_RST), 32'd3040);
    send_event(MODE_STICK, ACT_NONE, 1'b0, AXIS_HORIZ, 16'(THRESHOLD_RST) + 16'd1,
               32'hFFFF_FF00);
    // repeat across the timestamp wrap
    send_poll(32'h0000_0100);
    send_event(MODE_STICK, ACT_NONE, 1'b0, AXIS_VERT, -16'(THRESHOLD_RST) - 16'd1,
               32'h0000_0200);
    send_event(MODE_RELEASE, ACT_BAD_LOW + 4'd1, 1'b0, 2'($urandom), 16'($urandom),
               32'h0000_0210);
    send_event(MODE_PRESS, ACT_RIGHT, 1'b1, 2'($urandom), 16'($urandom), 32'h0000_0220);

    run_random(200);

    // everything zero: every poll with a hold repeats, any nonzero stick is a direction
    drain();
    configure(16'd0, 16'd0, 15'd0);
    run_random(200);

    // largest settings, no idling on either side
    drain();
    configure(16'hFFFF, 16'hFFFF, 15'h7FFF);
    quiet <= 1'b1;
    run_random(200);
    drain();
    quiet <= 1'b0;

    // settings near typical use, then fully random ones
    configure(16'($urandom_range(0, 400)), 16'($urandom_range(0, 150)), 15'($urandom));
    run_random(200);
    drain();
    configure(16'($urandom), 16'($urandom), 15'($urandom));
    run_random(200);
    drain();

    $display("tb: %0d events under %0d register settings, %0d results carried an action",
             sent_items, settings_used, sb.hits);
    $display("tb: key holds, stick sweeps, poll ticks across the wrap and random noise");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/aisq_pkg.sv
src/aisq_stick.sv
src/aisq_core.sv
src/input_autorepeat_stick_quantizer.sv
tb/tb_top.sv
